// ===== hdl/agr_pkg.sv =====
`default_nettype none
package agr_pkg;

	typedef struct packed {
		logic               func;
		logic [12:0]        row_index;
		logic [3:0]         elem_index;
		logic signed [31:0] value;
	} agr_in_t;

	typedef struct packed {
		logic signed [31:0] weight_out;
		logic [15:0]        shadow_out;
		logic [5:0]         scale_out;
		logic [2:0]         status;
	} agr_out_t;

	localparam logic [12:0] SKIP_ID      = 13'd4096;
	localparam logic [5:0]  SCALE_MAX    = 6'd48;
	localparam logic [34:0] SHADOW_LIMIT = 35'd256;
	localparam logic [47:0] ACC_MAX      = 48'hFFFF_FFFF_FFFF;

	localparam logic [2:0] ST_LOADED     = 3'd0;
	localparam logic [2:0] ST_PLAIN      = 3'd1;
	localparam logic [2:0] ST_COMPRESSED = 3'd2;
	localparam logic [2:0] ST_SKIPPED    = 3'd3;
	localparam logic [2:0] ST_SATURATED  = 3'd4;

	localparam logic [1:0] CFG_LR     = 2'd0;
	localparam logic [1:0] CFG_THRESH = 2'd1;
	localparam logic [1:0] CFG_INIT   = 2'd2;
	localparam logic [1:0] CFG_QUANT  = 2'd3;

	localparam int DIV_SHORT_BITS = 17;
	localparam int DIV_LONG_BITS  = 34;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_PREP,
		S_LQ,
		S_LQW,
		S_MUL1,
		S_ACC,
		S_ROOT,
		S_QWAIT,
		S_QCHK,
		S_QNEXT,
		S_QSTART,
		S_MUL2,
		S_SDIV,
		S_SWAIT,
		S_FIN
	} agr_state_t;

	typedef struct packed {
		logic        start;
		logic        long_mode;
		logic [63:0] y;
		logic [63:0] d;
	} agr_div_req_t;

	typedef struct packed {
		logic        busy;
		logic        ovf;
		logic [33:0] q;
	} agr_div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/agr_div.sv =====
`default_nettype none
module agr_div
	import agr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire agr_div_req_t req,
	output agr_div_rsp_t      rsp
);

	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [63:0] yq_q;
	logic [33:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        ovf_q;

	logic [63:0] r0;
	logic        ovf0;
	logic [64:0] r2;
	logic        ge;

	always_comb begin
		r0   = req.long_mode ? (req.y >> DIV_LONG_BITS) : (req.y >> DIV_SHORT_BITS);
		ovf0 = r0 >= req.d;
		r2   = {rem_q, yq_q[63]};
		ge   = r2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= !ovf0;
			ovf_q  <= ovf0;
			cnt_q  <= req.long_mode ? 6'(DIV_LONG_BITS) : 6'(DIV_SHORT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= r0;
			den_q <= req.d;
			yq_q  <= req.long_mode ? (req.y << (64 - DIV_LONG_BITS))
			                       : (req.y << (64 - DIV_SHORT_BITS));
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(r2 - {1'b0, den_q}) : r2[63:0];
			yq_q  <= {yq_q[62:0], 1'b0};
			quo_q <= {quo_q[32:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.q    = quo_q;

endmodule
`default_nettype wire

// ===== hdl/agr_isqrt.sv =====
`default_nettype none
module agr_isqrt
	import agr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] v,
	output logic             busy,
	output logic [23:0]      root
);

	logic [47:0] v_q;
	logic [47:0] res_q;
	logic [46:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [48:0] sum;
	logic        take;

	always_comb begin
		sum  = {1'b0, res_q} + {2'b0, bit_q};
		take = {1'b0, v_q} >= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd24;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v;
			res_q <= '0;
			bit_q <= 47'd1 << 46;
		end else if (busy_q) begin
			if (take) begin
				v_q   <= 48'({1'b0, v_q} - sum);
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[23:0];

endmodule
`default_nettype wire

// ===== hdl/adagrad_lowprec_row_update.sv =====
// A skipped word goes straight out, a load runs a short division, an update the square root
// and the long step division; a compressed one adds short divisions, one more per quantum doubling.
// Throughput: one word at a time; the 1-bit-per-cycle divider (17 or 34 steps) and
// the 24-step square root unit set the pace. A new word is taken while a result waits.
// Reset: control, scale exponent and registers return to defaults; the weight,
// accumulator and shadow stores hold nothing valid until written, no clearing pass.
`default_nettype none
module adagrad_lowprec_row_update
	import agr_pkg::*;
#(
	parameter int ROWS      = 4096,
	parameter int ROW_ELEMS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire agr_in_t     in_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output agr_out_t         out_word,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);

	localparam int DEPTH = ROWS * ROW_ELEMS;
	localparam int AW    = $clog2(DEPTH);

	logic [31:0] wmem [DEPTH];
	logic [47:0] amem [DEPTH];
	logic [21:0] smem [DEPTH];

	agr_state_t state_q, state_d;

	logic [23:0] lr_q;
	logic [11:0] thr_q;
	logic [47:0] init_q;
	logic [31:0] bq_q;
	logic [5:0]  scale_q;

	agr_in_t     item_q;
	logic [AW-1:0] idx_q;
	logic        skip_q;
	logic        low_q;
	logic [31:0] mag_q;
	logic signed [31:0] w_q;
	logic [47:0] acc_q;
	logic [63:0] diff_q;
	logic [15:0] sh_q;
	logic        sat_q;

	logic [31:0] wrd_q;
	logic [47:0] ard_q;
	logic [21:0] srd_q;

	logic [63:0] qd_q;
	logic        qz_q;
	logic [80:0] qd_full;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	agr_div_req_t div_req;
	agr_div_rsp_t div_rsp;
	logic        sqrt_start;
	logic        sqrt_busy;
	logic [23:0] root;

	logic        accept;
	logic        in_skip;
	logic [AW-1:0] in_idx;
	logic        out_free;

	logic [64:0] acc_sum;
	logic [33:0] qv;
	logic [34:0] rsum;
	logic signed [35:0] wn;
	logic [35:0] stepv;

	logic fin_step_q;
	logic step_done;

	agr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	agr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.v      (acc_q),
		.busy   (sqrt_busy),
		.root   (root)
	);

	always_comb begin
		in_skip = (in_word.row_index == SKIP_ID)
		       || (32'(in_word.row_index) >= 32'(ROWS))
		       || (32'(in_word.elem_index) >= 32'(ROW_ELEMS));
		in_idx  = AW'(32'(in_word.row_index) * 32'(ROW_ELEMS) + 32'(in_word.elem_index));
		accept  = in_valid && in_ready;
		out_free = !out_valid || out_ready;
		qd_full = 81'((bq_q == 32'd0) ? 32'd1 : bq_q) << scale_q;
		acc_sum = {17'd0, acc_q} + {1'b0, prod_q};
		qv      = qz_q ? 34'd0 : (div_rsp.ovf ? {34{1'b1}} : div_rsp.q);
		rsum    = 35'(sh_q) + 35'(qv);
		stepv   = {2'b00, div_rsp.q};
		wn      = 36'(w_q) - (item_q.value[31] ? -$signed(stepv) : $signed(stepv));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		sqrt_start     = 1'b0;
		div_req.start  = 1'b0;
		div_req.long_mode = 1'b0;
		div_req.y      = diff_q + (qd_q >> 1);
		div_req.d      = qd_q;
		mul_a          = mag_q;
		mul_b          = mag_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = in_skip ? S_FIN : S_READ;
				end
			end
			S_READ: state_d = S_PREP;
			S_PREP: state_d = item_q.func ? S_MUL1 : S_LQ;
			S_LQ: begin
				div_req.y     = {16'd0, init_q} + (qd_q >> 1);
				div_req.start = !qz_q;
				state_d       = qz_q ? S_FIN : S_LQW;
			end
			S_LQW: if (!div_rsp.busy) begin
				state_d = S_FIN;
			end
			S_MUL1: state_d = S_ACC;
			S_ACC: state_d = S_ROOT;
			S_ROOT: begin
				sqrt_start    = 1'b1;
				div_req.start = low_q && !qz_q;
				state_d       = S_QWAIT;
			end
			S_QWAIT: if (!div_rsp.busy && !sqrt_busy) begin
				state_d = low_q ? S_QCHK : S_MUL2;
			end
			S_QCHK: begin
				if (rsum < SHADOW_LIMIT || scale_q >= SCALE_MAX) begin
					state_d = S_MUL2;
				end else begin
					state_d = S_QNEXT;
				end
			end
			S_QNEXT: state_d = S_QSTART;
			S_QSTART: begin
				div_req.start = !qz_q;
				state_d       = S_QWAIT;
			end
			S_MUL2: begin
				mul_b   = {8'd0, lr_q};
				state_d = (root == 24'd0) ? S_FIN : S_SDIV;
			end
			S_SDIV: begin
				div_req.start     = 1'b1;
				div_req.long_mode = 1'b1;
				div_req.y         = prod_q + {40'd0, root >> 1};
				div_req.d         = {40'd0, root};
				state_d           = S_SWAIT;
			end
			S_SWAIT: if (!div_rsp.busy) begin
				state_d = S_FIN;
			end
			S_FIN: if (out_free && !fin_step_q) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// S_FIN with the step division finished applies the step before the word leaves
	assign step_done = (state_q == S_SWAIT) && !div_rsp.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q       <= 24'd655;
			thr_q      <= 12'd4095;
			init_q     <= 48'd429496730;
			bq_q       <= 32'd4294967;
			scale_q    <= '0;
			out_valid  <= 1'b0;
			fin_step_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LR:     lr_q   <= cfg_data[23:0];
					CFG_THRESH: thr_q  <= cfg_data[11:0];
					CFG_INIT:   init_q <= cfg_data;
					CFG_QUANT:  bq_q   <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (state_q == S_QCHK && rsum >= SHADOW_LIMIT && scale_q < SCALE_MAX) begin
				scale_q <= scale_q + 6'd1;
			end
			if (state_q == S_FIN && out_free && !fin_step_q) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			fin_step_q <= step_done;
		end
	end

	always_ff @(posedge clk) begin
		prod_q  <= mul_a * mul_b;
		qd_q    <= qd_full[63:0];
		qz_q    <= qd_full > (81'd1 << 63);
		wrd_q   <= wmem[idx_q];
		ard_q   <= amem[idx_q];
		srd_q   <= smem[idx_q];
		if (accept) begin
			item_q <= in_word;
			idx_q  <= in_idx;
			skip_q <= in_skip;
			low_q  <= 32'(in_word.row_index) <= 32'(thr_q);
			mag_q  <= in_word.value[31] ? 32'(-in_word.value) : 32'(in_word.value);
			sat_q  <= 1'b0;
		end
		case (state_q)
			S_PREP: begin
				w_q   <= wrd_q;
				acc_q <= ard_q;
				sh_q  <= srd_q[15:0] >> (scale_q - srd_q[21:16]);
			end
			S_LQ: begin
				w_q   <= item_q.value;
				acc_q <= init_q;
				if (qz_q) begin
					sh_q <= '0;
				end
			end
			S_LQW: if (!div_rsp.busy) begin
				sh_q <= (div_rsp.ovf || div_rsp.q > 34'd65535) ? 16'hFFFF : div_rsp.q[15:0];
			end
			S_ACC: begin
				diff_q <= prod_q;
				if (acc_sum > {17'd0, ACC_MAX}) begin
					acc_q <= ACC_MAX;
					sat_q <= 1'b1;
				end else begin
					acc_q <= acc_sum[47:0];
				end
			end
			S_QCHK: begin
				if (rsum < SHADOW_LIMIT) begin
					sh_q <= rsum[15:0];
				end else if (scale_q >= SCALE_MAX) begin
					sh_q  <= 16'd255;
					sat_q <= 1'b1;
				end else begin
					sh_q <= sh_q >> 1;
				end
			end
			default: ;
		endcase
		if (fin_step_q && state_q == S_FIN) begin
			if (div_rsp.ovf) begin
				w_q   <= item_q.value[31] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				sat_q <= 1'b1;
			end else if (wn > 36'sd2147483647) begin
				w_q   <= 32'sh7FFF_FFFF;
				sat_q <= 1'b1;
			end else if (wn < -36'sd2147483648) begin
				w_q   <= 32'sh8000_0000;
				sat_q <= 1'b1;
			end else begin
				w_q <= wn[31:0];
			end
		end
		if (state_q == S_FIN && out_free && !fin_step_q) begin
			if (skip_q) begin
				out_word.weight_out <= '0;
				out_word.shadow_out <= '0;
				out_word.status     <= ST_SKIPPED;
			end else begin
				out_word.weight_out <= w_q;
				out_word.shadow_out <= sh_q;
				out_word.status     <= !item_q.func ? ST_LOADED
				                     : sat_q ? ST_SATURATED
				                     : low_q ? ST_COMPRESSED : ST_PLAIN;
			end
			out_word.scale_out <= scale_q;
			if (!skip_q) begin
				wmem[idx_q] <= w_q;
				amem[idx_q] <= acc_q;
				smem[idx_q] <= {scale_q, sh_q};
			end
		end
	end

`ifndef SYNTHESIS
	a_scale_max: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q <= SCALE_MAX) else $error("scale exponent above limit");
	a_scale_step: assert property (@(posedge clk) disable iff (!arst_n)
		(scale_q != $past(scale_q)) |-> (scale_q == $past(scale_q) + 6'd1))
		else $error("scale exponent moved by more than one");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_busy) else $error("sqrt restarted while busy");
`endif

endmodule
`default_nettype wire

// ===== sim/agr_checker.sv =====
module agr_checker
	import agr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire agr_in_t     in_word,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire agr_out_t    out_word,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ROWS  = 4096;
	localparam int N_ELEMS = 16;

	logic signed [31:0] weights [int];
	logic [47:0]        accums  [int];
	logic [15:0]        shadows [int];
	logic [5:0]         scale_exp;
	logic [23:0]        lr;
	logic [11:0]        thresh;
	logic [47:0]        init_acc;
	logic [31:0]        quantum;
	agr_out_t           expected_words [$];
	int                 mismatches;

	assign pending = expected_words.size();
	assign fail_count = mismatches;

	function automatic logic [63:0] quant_round(logic [63:0] x, logic [5:0] s);
		logic [63:0] b;
		logic [63:0] d;
		b = (quantum == 0) ? 64'd1 : {32'd0, quantum};
		if (s >= 63 || b > ((64'd1 << 63) >> s))
			return 0;
		d = b << s;
		return (x + d / 2) / d;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic agr_out_t adagrad_step(agr_in_t w);
		agr_out_t r;
		int idx;
		logic [63:0] mag, diff, acc, root, num, sh, sum;
		longint wt, stp;
		logic sat;
		r = '0;
		sat = 0;
		if (w.row_index == SKIP_ID || w.row_index >= N_ROWS || w.elem_index >= N_ELEMS) begin
			r.scale_out = scale_exp;
			r.status = ST_SKIPPED;
			return r;
		end
		idx = w.row_index * N_ELEMS + w.elem_index;
		if (w.func == 1'b0) begin
			sh = quant_round({16'd0, init_acc}, scale_exp);
			weights[idx] = w.value;
			accums[idx] = init_acc;
			shadows[idx] = (sh > 64'hFFFF) ? 16'hFFFF : sh[15:0];
			r.status = ST_LOADED;
		end else begin
			mag = (w.value < 0) ? -longint'(w.value) : longint'(w.value);
			diff = mag * mag;
			acc = accums.exists(idx) ? {16'd0, accums[idx]} : 0;
			wt = weights.exists(idx) ? longint'(weights[idx]) : 0;
			if (diff > {16'd0, ACC_MAX} - acc) begin
				acc = {16'd0, ACC_MAX};
				sat = 1;
			end else begin
				acc = acc + diff;
			end
			accums[idx] = acc[47:0];
			if (w.row_index <= thresh) begin
				forever begin
					sum = {48'd0, shadows[idx]} + quant_round(diff, scale_exp);
					if (sum < 256) begin
						shadows[idx] = sum[15:0];
						break;
					end
					if (scale_exp >= SCALE_MAX) begin
						shadows[idx] = 16'd255;
						sat = 1;
						break;
					end
					scale_exp++;
					foreach (shadows[k])
						shadows[k] = shadows[k] >> 1;
				end
				r.status = ST_COMPRESSED;
			end else begin
				r.status = ST_PLAIN;
			end
			root = int_sqrt(acc);
			if (root != 0) begin
				num = mag * lr;
				stp = longint'((num + root / 2) / root);
				if (w.value < 0)
					stp = -stp;
				wt = wt - stp;
				if (wt > 64'sd2147483647) begin
					wt = 2147483647;
					sat = 1;
				end
				if (wt < -64'sd2147483648) begin
					wt = -2147483648;
					sat = 1;
				end
				weights[idx] = wt[31:0];
			end
			if (sat)
				r.status = ST_SATURATED;
		end
		r.weight_out = weights.exists(idx) ? weights[idx] : 0;
		r.shadow_out = shadows[idx];
		r.scale_out = scale_exp;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		agr_out_t e;
		if (!arst_n) begin
			scale_exp = 0;
			lr = 24'd655;
			thresh = 12'd4095;
			init_acc = 48'd429496730;
			quantum = 32'd4294967;
			mismatches = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LR: lr = cfg_data[23:0];
					CFG_THRESH: thresh = cfg_data[11:0];
					CFG_INIT: init_acc = cfg_data;
					CFG_QUANT: quantum = cfg_data[31:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h", out_word);
				end else begin
					e = expected_words.pop_front();
					if (e !== out_word) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp w=%h sh=%h sc=%0d st=%0d got w=%h sh=%h sc=%0d st=%0d",
								e.weight_out, e.shadow_out, e.scale_out, e.status,
								out_word.weight_out, out_word.shadow_out,
								out_word.scale_out, out_word.status);
					end
				end
			end
			if (in_valid && in_ready)
				expected_words.push_back(adagrad_step(in_word));
		end
	end
endmodule

// ===== sim/tb_adagrad_lowprec_row_update.sv =====
module tb_adagrad_lowprec_row_update;
	import agr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	agr_in_t     in_word;
	logic        out_valid;
	logic        out_ready;
	agr_out_t    out_word;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;
	int          fail_count;
	int          pending;
	int          send_idle;
	int          recv_stall;
	int          hold_off;
	logic        loaded [int];
	int          load_list [$];

	adagrad_lowprec_row_update dut (.*);

	agr_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stall, plus an optional long hold-off
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic send_word(agr_in_t w);
		int key;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		key = int'({w.row_index, w.elem_index});
		if (w.row_index < 4096 && w.func == 0)
			if (!loaded.exists(key)) begin
				loaded[key] = 1;
				load_list.push_back(key);
			end
	endtask

	function automatic logic [31:0] rand_grad();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(255) - 128;
			2: return $urandom_range(32'h1FFFF) - 32'hFFFF;
			default: return $urandom_range(32'h3FFFF) - 32'h1FFFF;
		endcase
	endfunction

	task automatic load_elem(logic [12:0] r, logic [3:0] e, logic [31:0] v);
		agr_in_t w;
		w.func = 0;
		w.row_index = r;
		w.elem_index = e;
		w.value = v;
		send_word(w);
	endtask

	task automatic update_elem(int key, logic [31:0] g);
		agr_in_t w;
		w.func = 1;
		w.row_index = key[16:4];
		w.elem_index = key[3:0];
		w.value = g;
		send_word(w);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] i, logic [47:0] d);
		cfg_we <= 1;
		cfg_index <= i;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int n);
		agr_in_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 2 || load_list.size() == 0) begin
				load_elem(13'($urandom_range(4095)), 4'($urandom), $urandom);
			end else if ($urandom_range(19) == 0) begin
				w.func = 1'($urandom);
				w.elem_index = 4'($urandom);
				w.value = $urandom;
				w.row_index = 13'(4096 + $urandom_range(4095));
				send_word(w);
			end else begin
				update_elem(load_list[$urandom_range(load_list.size() - 1)], rand_grad());
			end
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_word = '0;
		cfg_we = 0;
		cfg_index = CFG_LR;
		cfg_data = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		load_elem(0, 0, 32'h7FFFFFFF);
		load_elem(4095, 15, 32'h80000000);
		load_elem(10, 3, 0);
		update_elem(0, 32'h80000000);
		update_elem({13'd4095, 4'd15}, 32'h7FFFFFFF);
		update_elem({13'd10, 4'd3}, 0);
		update_elem({13'd10, 4'd3}, 32'hFFFFFFFF);
		update_elem({13'd10, 4'd3}, 32'h00010000);
		update_elem({13'd10, 4'd3}, 32'hFFFF0000);
		load_elem(4096, 0, 32'h1234);
		load_elem(8191, 15, 32'hFFFFFFFF);
		update_elem({13'd4096, 4'd5}, 32'h100);
		drain();

		write_reg(CFG_INIT, 0);
		write_reg(CFG_LR, 48'hFFFFFF);
		write_reg(CFG_QUANT, 0);
		write_reg(CFG_THRESH, 0);
		load_elem(0, 1, 32'h7FFF0000);
		update_elem(1, 32'h00000001);
		update_elem(1, 32'hFFFF0000);
		load_elem(1, 1, 32'h80000000);
		update_elem({13'd1, 4'd1}, 32'h40000000);
		update_elem({13'd1, 4'd1}, 32'h7FFFFFFF);
		update_elem(1, 32'h80000000);
		update_elem(1, 32'h7FFFFFFF);
		drain();

		write_reg(CFG_INIT, 48'hFFFFFFFFFFFF);
		write_reg(CFG_QUANT, 48'hFFFFFFFF);
		write_reg(CFG_THRESH, 48'd4095);
		write_reg(CFG_LR, 0);
		load_elem(2, 2, 32'h1);
		update_elem({13'd2, 4'd2}, 32'h5);
		drain();

		write_reg(CFG_LR, 655);
		write_reg(CFG_INIT, 48'd429496730);
		write_reg(CFG_QUANT, 48'd4294967);
		random_phase(400);
		drain();

		send_idle = 69;
		write_reg(CFG_THRESH, 48'd2047);
		write_reg(CFG_LR, 48'h010000);
		write_reg(CFG_QUANT, 48'd65536);
		random_phase(350);
		drain();

		send_idle = 0;
		recv_stall = 69;
		write_reg(CFG_LR, 48'($urandom));
		write_reg(CFG_INIT, 48'({$urandom, $urandom}));
		write_reg(CFG_QUANT, 48'($urandom | 32'h100));
		random_phase(350);
		drain();

		send_idle = 20;
		recv_stall = 20;
		write_reg(CFG_THRESH, 48'($urandom));
		write_reg(CFG_QUANT, 48'd1);
		write_reg(CFG_INIT, 48'd4294967296);
		random_phase(300);
		hold_off = 400;
		random_phase(40);
		// let everything arrive before the last stretch
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		send_idle = 0;
		recv_stall = 0;
		random_phase(400);
		drain();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
